[hdl/pdc_pkg.sv]
package pdc_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 1'd1;

  localparam logic [7:0]  START_BYTE_RST = 8'hA1;
  localparam logic [7:0]  MAX_LENGTH_RST = 8'd200;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;

  // Live configuration values
  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] max_length;
  } pdc_cfg_t;

  // One result item
  typedef struct packed {
    logic [7:0] pkt_type;
    logic [7:0] pkt_length;
    logic       has_data;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic       last;
    logic       crc_ok;
  } pdc_res_t;

  // One byte of CRC-16/MCRF4XX (reflected 0x8408), table-free form
  function automatic logic [15:0] crc_step(input logic [7:0] b, input logic [15:0] c);
    logic [7:0]  x;
    logic [15:0] r;
    x = b ^ c[7:0];
    x = x ^ {x[3:0], 4'd0};
    r = {x, c[15:8]} ^ {12'd0, x[7:4]} ^ {5'd0, x, 3'd0};
    return r;
  endfunction

endpackage

[hdl/pdc_byte_if.sv]
interface pdc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

[hdl/pdc_res_if.sv]
interface pdc_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] pkt_type;
  logic [7:0] pkt_length;
  logic       has_data;
  logic [7:0] data_byte;
  logic [7:0] byte_index;
  logic       last;
  logic       crc_ok;

  modport source (
    output valid, output pkt_type, output pkt_length, output has_data,
    output data_byte, output byte_index, output last, output crc_ok,
    input ready
  );
  modport sink (
    input valid, input pkt_type, input pkt_length, input has_data,
    input data_byte, input byte_index, input last, input crc_ok,
    output ready
  );
endinterface

[hdl/pdc_cfg.sv]
module pdc_cfg
  import pdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  we,
  input  logic [CFG_IDX_W-1:0]  index,
  input  logic [CFG_DATA_W-1:0] data,
  output pdc_cfg_t              cfg
);

  // Register file, written in place
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte <= START_BYTE_RST;
      cfg.max_length <= MAX_LENGTH_RST;
    end else if (we) begin
      case (index)
        REG_START_BYTE: cfg.start_byte <= data;
        REG_MAX_LENGTH: cfg.max_length <= data;
        default: ;
      endcase
    end
  end

endmodule

[hdl/pdc_fsm.sv]
module pdc_fsm
  import pdc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  pdc_cfg_t   cfg,
  input  logic       go,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  output pdc_res_t   res
);

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_TYPE    = 3'd1;
  localparam logic [2:0] PH_LENGTH  = 3'd2;
  localparam logic [2:0] PH_CRC_LO  = 3'd3;
  localparam logic [2:0] PH_CRC_HI  = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;

  logic [2:0]  phase, phase_next;
  logic [7:0]  held_type, held_length;
  logic [15:0] received_check;
  logic [15:0] running_check;
  logic [7:0]  payload_count;

  logic [15:0] crc_in;
  logic [15:0] crc_upd;
  logic [7:0]  count_inc;
  logic [15:0] rcv_full;

  // One CRC update per type, length and payload byte; the type byte starts from the initial value
  assign crc_in    = (phase == PH_TYPE) ? CRC_INIT : running_check;
  assign crc_upd   = crc_step(rx_byte, crc_in);
  assign count_inc = payload_count + 8'd1;
  assign rcv_full  = {rx_byte, received_check[7:0]};

  // Next phase and result for the byte at the stage input
  always_comb begin
    phase_next     = phase;
    res_valid      = 1'b0;
    res.pkt_type   = held_type;
    res.pkt_length = held_length;
    res.has_data   = 1'b0;
    res.data_byte  = 8'd0;
    res.byte_index = 8'd0;
    res.last       = 1'b0;
    res.crc_ok     = 1'b0;
    case (phase)
      PH_TYPE:   phase_next = PH_LENGTH;
      PH_LENGTH: phase_next = (rx_byte > cfg.max_length) ? PH_HUNT : PH_CRC_LO;
      PH_CRC_LO: phase_next = PH_CRC_HI;
      PH_CRC_HI: begin
        if (held_length == 8'd0) begin
          // empty packet: verdict comes with the CRC high byte
          phase_next = PH_HUNT;
          res_valid  = go;
          res.last   = 1'b1;
          res.crc_ok = (rcv_full == running_check);
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        res_valid      = go;
        res.has_data   = 1'b1;
        res.data_byte  = rx_byte;
        res.byte_index = payload_count;
        if (count_inc == held_length) begin
          phase_next = PH_HUNT;
          res.last   = 1'b1;
          res.crc_ok = (received_check == crc_upd);
        end
      end
      default: phase_next = (rx_byte == cfg.start_byte) ? PH_TYPE : PH_HUNT;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      payload_count <= 8'd0;
    end else if (go) begin
      phase <= phase_next;
      if (phase == PH_CRC_HI) begin
        payload_count <= 8'd0;
      end else if (phase == PH_PAYLOAD) begin
        payload_count <= (count_inc == held_length) ? 8'd0 : count_inc;
      end
    end
  end

  // Header and CRC holding registers
  always_ff @(posedge clk) begin
    if (rst) begin
      held_type      <= 8'd0;
      held_length    <= 8'd0;
      received_check <= 16'd0;
      running_check  <= CRC_INIT;
    end else if (go) begin
      case (phase)
        PH_TYPE: begin
          held_type     <= rx_byte;
          running_check <= crc_upd;
        end
        PH_LENGTH: begin
          if (rx_byte <= cfg.max_length) begin
            held_length   <= rx_byte;
            running_check <= crc_upd;
          end
        end
        PH_CRC_LO:  received_check[7:0]  <= rx_byte;
        PH_CRC_HI:  received_check[15:8] <= rx_byte;
        PH_PAYLOAD: running_check        <= crc_upd;
        default:    running_check        <= CRC_INIT;
      endcase
    end
  end

  a_res_phase: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (phase == PH_CRC_HI || phase == PH_PAYLOAD))
    else $error("result outside CRC-high or payload phase");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.last && res.has_data) |->
      (res.byte_index == 8'(res.pkt_length - 8'd1)))
    else $error("last payload byte index does not match length");

  a_ok_needs_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.crc_ok) |-> res.last)
    else $error("crc verdict on a non-final result");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (payload_count < held_length))
    else $error("payload count ran past packet length");

endmodule

[hdl/pdc_obuf.sv]
module pdc_obuf
  import pdc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     load,
  input  pdc_res_t din,
  output logic     space,
  output logic     valid,
  input  logic     ready,
  output pdc_res_t dout
);

  // Single result register; refilled in the cycle it drains
  assign space = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dout <= din;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> space)
    else $error("result register overwritten while stalled");

endmodule

[hdl/packet_deframer_crc16.sv]
// Byte-serial packet receiver: hunts for the start byte, reads type, length
// and the CRC-16/MCRF4XX (low byte first), then streams each payload byte out
// with its index. The final result (last payload byte, or the CRC high byte of
// an empty packet) carries last = 1 and crc_ok; drop packets flagged bad.
// Lengths above max_length are discarded silently and hunting resumes. The
// block takes one byte per clock as long as results drain; while a result is
// stalled in the result register, every byte, with or without a result, waits
// in the input register and the input stops once that register is full. A
// result goes from its byte in the input register through the combinational
// CRC and phase logic into the result register. Configuration writes take
// effect on the next clock.
module packet_deframer_crc16
  import pdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  pdc_byte_if.sink              rx,
  pdc_res_if.source             res
);

  pdc_cfg_t   cfg;
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       go;
  logic       space;
  logic       res_load;
  pdc_res_t   res_d;
  pdc_res_t   res_q;

  pdc_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  // Input register; advances whenever the result side has room
  assign go       = s1_valid && space;
  assign rx.ready = !s1_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      s1_valid <= 1'b1;
    end else if (go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      s1_byte <= rx.rx_byte;
    end
  end

  pdc_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .go        (go),
    .rx_byte   (s1_byte),
    .res_valid (res_load),
    .res       (res_d)
  );

  pdc_obuf u_obuf (
    .clk   (clk),
    .rst   (rst),
    .load  (res_load),
    .din   (res_d),
    .space (space),
    .valid (res.valid),
    .ready (res.ready),
    .dout  (res_q)
  );

  assign res.pkt_type   = res_q.pkt_type;
  assign res.pkt_length = res_q.pkt_length;
  assign res.has_data   = res_q.has_data;
  assign res.data_byte  = res_q.data_byte;
  assign res.byte_index = res_q.byte_index;
  assign res.last       = res_q.last;
  assign res.crc_ok     = res_q.crc_ok;

endmodule

[tb/sv/tb_packet_deframer_crc16.sv]
`timescale 1ns / 1ps

module tb_packet_deframer_crc16;
  import pdc_pkg::*;

  // Deframer phases, as tracked by the predictor
  typedef enum logic [2:0] {
    ST_HUNT, ST_TYPE, ST_LEN, ST_CRC_LO, ST_CRC_HI, ST_PAYLOAD
  } deframe_st_t;

  // One row of the directed stimulus
  typedef struct {
    logic [7:0] b;
    bit         typed;
    pdc_res_t   want;
  } stim_row_t;

  localparam pdc_res_t NO_RES      = '0;
  localparam pdc_res_t ZLEN_GOOD   = '{8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 1'b1, 1'b1};
  localparam pdc_res_t ZLEN_BAD_FF = '{8'hFF, 8'h00, 1'b0, 8'h00, 8'h00, 1'b1, 1'b0};

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pdc_byte_if byte_if ();
  pdc_res_if  result_if ();

  packet_deframer_crc16 uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx        (byte_if),
    .res       (result_if)
  );

  // Idle rates in percent, changed per phase
  int send_idle_pct = 7;
  int recv_idle_pct = 62;

  // Predictor state and its copy of the registers
  deframe_st_t st;
  logic [7:0]  start_cfg;
  logic [7:0]  maxlen_cfg;
  logic [7:0]  p_type;
  logic [7:0]  p_len;
  logic [15:0] rx_crc;
  logic [15:0] run_crc;
  logic [7:0]  p_count;

  pdc_res_t   expected_results [$];
  logic [7:0] frame_q [$];
  int         mismatch_cnt = 0;

  // Directed bytes: hunting noise, zero-length good and bad, oversize length,
  // a two-byte payload, and the start value reused as a type byte
  stim_row_t dir_tbl [27] = '{
    '{8'h00, 1'b0, NO_RES}, '{8'hFF, 1'b0, NO_RES},
    '{8'hA1, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
    '{8'hB8, 1'b0, NO_RES}, '{8'hF0, 1'b1, ZLEN_GOOD},
    '{8'hA1, 1'b0, NO_RES}, '{8'hFF, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b1, ZLEN_BAD_FF},
    '{8'hA1, 1'b0, NO_RES}, '{8'h7E, 1'b0, NO_RES}, '{8'hC9, 1'b0, NO_RES},
    '{8'hA1, 1'b0, NO_RES}, '{8'h3C, 1'b0, NO_RES}, '{8'h02, 1'b0, NO_RES},
    '{8'h34, 1'b0, NO_RES}, '{8'h12, 1'b0, NO_RES}, '{8'hFF, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'hA1, 1'b0, NO_RES}, '{8'hA1, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}
  };

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // CRC-16/MCRF4XX, bit-serial, reflected poly 0x8408
  function automatic logic [15:0] mcrf4xx_byte(input logic [7:0] b, input logic [15:0] c);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ 16'h8408) : (r >> 1);
    end
    return r;
  endfunction

  task automatic deframe_reset();
    start_cfg  = START_BYTE_RST;
    maxlen_cfg = MAX_LENGTH_RST;
    st         = ST_HUNT;
    p_type     = 8'h00;
    p_len      = 8'h00;
    rx_crc     = 16'h0000;
    run_crc    = CRC_INIT;
    p_count    = 8'h00;
  endtask

  // Advance the predictor by one byte; produced says whether a result follows
  task automatic deframe_byte(input logic [7:0] b, output bit produced, output pdc_res_t r);
    logic [7:0] idx;
    produced = 1'b0;
    r        = NO_RES;
    case (st)
      ST_TYPE: begin
        p_type  = b;
        run_crc = mcrf4xx_byte(b, CRC_INIT);
        st      = ST_LEN;
      end
      ST_LEN: begin
        if (b > maxlen_cfg) begin
          st = ST_HUNT;
        end else begin
          p_len   = b;
          run_crc = mcrf4xx_byte(b, run_crc);
          st      = ST_CRC_LO;
        end
      end
      ST_CRC_LO: begin
        rx_crc = {8'h00, b};
        st     = ST_CRC_HI;
      end
      ST_CRC_HI: begin
        rx_crc[15:8] = b;
        p_count      = 8'h00;
        if (p_len == 8'h00) begin
          produced = 1'b1;
          r = '{p_type, p_len, 1'b0, 8'h00, 8'h00, 1'b1, rx_crc == run_crc};
          st = ST_HUNT;
        end else begin
          st = ST_PAYLOAD;
        end
      end
      ST_PAYLOAD: begin
        idx      = p_count;
        run_crc  = mcrf4xx_byte(b, run_crc);
        p_count  = p_count + 8'd1;
        produced = 1'b1;
        if (p_count == p_len) begin
          r = '{p_type, p_len, 1'b1, b, idx, 1'b1, rx_crc == run_crc};
          p_count = 8'h00;
          st = ST_HUNT;
        end else begin
          r = '{p_type, p_len, 1'b1, b, idx, 1'b0, 1'b0};
        end
      end
      default: begin
        if (b == start_cfg) begin
          run_crc = CRC_INIT;
          st      = ST_TYPE;
        end else begin
          st = ST_HUNT;
        end
      end
    endcase
  endtask

  // Offer one byte until it transfers, then queue what it should produce
  task automatic send_byte(input logic [7:0] b, input bit typed, input pdc_res_t want);
    bit       done;
    bit       produced;
    pdc_res_t r;
    done = 1'b0;
    while (!done) begin
      @(negedge clk);
      if ($urandom_range(0, 99) < send_idle_pct) begin
        byte_if.valid   = 1'b0;
        byte_if.rx_byte = $urandom;
      end else begin
        byte_if.valid   = 1'b1;
        byte_if.rx_byte = b;
      end
      @(posedge clk);
      if (byte_if.valid && byte_if.ready) done = 1'b1;
    end
    deframe_byte(b, produced, r);
    if (produced) expected_results.push_back(typed ? want : r);
  endtask

  // Let every pending result arrive, plus the pipeline depth
  task automatic drain();
    @(negedge clk);
    byte_if.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    if (idx == REG_START_BYTE) start_cfg = val;
    else if (idx == REG_MAX_LENGTH) maxlen_cfg = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Build one random frame into frame_q: noise, oversize length, truncated
  // frame, or a full frame whose CRC is usually right
  task automatic build_frame(output bit noise);
    int          kind;
    int          len;
    int          cut;
    int          r;
    logic [7:0]  t;
    logic [7:0]  pl;
    logic [15:0] crc;
    logic [7:0]  payload [$];
    frame_q.delete();
    noise = 1'b0;
    kind  = $urandom_range(0, 99);
    t     = $urandom;
    if (kind < 8) begin
      noise = 1'b1;
      repeat ($urandom_range(1, 4)) frame_q.push_back($urandom);
    end else if (kind < 16 && maxlen_cfg != 8'hFF) begin
      frame_q.push_back(start_cfg);
      frame_q.push_back(t);
      frame_q.push_back($urandom_range(int'(maxlen_cfg) + 1, 255));
    end else begin
      r = $urandom_range(0, 99);
      if (r < 4) len = maxlen_cfg;
      else if (r < 8) len = $urandom_range(0, maxlen_cfg);
      else len = $urandom_range(0, (maxlen_cfg < 8) ? maxlen_cfg : 8);
      crc = mcrf4xx_byte(t, CRC_INIT);
      crc = mcrf4xx_byte(len[7:0], crc);
      for (int i = 0; i < len; i++) begin
        pl  = $urandom;
        crc = mcrf4xx_byte(pl, crc);
        payload.push_back(pl);
      end
      if ($urandom_range(0, 99) < 15) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
      frame_q.push_back(start_cfg);
      frame_q.push_back(t);
      frame_q.push_back(len[7:0]);
      frame_q.push_back(crc[7:0]);
      frame_q.push_back(crc[15:8]);
      foreach (payload[i]) frame_q.push_back(payload[i]);
      // broken frame: stream continues with the next frame's bytes
      if (kind < 22) begin
        cut = $urandom_range(1, frame_q.size() - 1);
        while (frame_q.size() > cut) void'(frame_q.pop_back());
      end
    end
  endtask

  // Result side: random stall, compare each transfer with the oldest expectation
  always @(negedge clk) begin
    result_if.ready = ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : result_check
    pdc_res_t got;
    pdc_res_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      got = {result_if.pkt_type, result_if.pkt_length, result_if.has_data,
             result_if.data_byte, result_if.byte_index, result_if.last, result_if.crc_ok};
      if (expected_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display({"unexpected result at %0t: type=%02h len=%02h has=%0b data=%02h",
                    " idx=%0d last=%0b ok=%0b"},
                   $realtime, got.pkt_type, got.pkt_length, got.has_data, got.data_byte,
                   got.byte_index, got.last, got.crc_ok);
      end else begin
        want = expected_results.pop_front();
        if (got.pkt_type !== want.pkt_type || got.pkt_length !== want.pkt_length ||
            got.has_data !== want.has_data || got.data_byte !== want.data_byte ||
            got.byte_index !== want.byte_index || got.last !== want.last ||
            got.crc_ok !== want.crc_ok) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch at %0t", $realtime);
            $display("  expected type=%02h len=%02h has=%0b data=%02h idx=%0d last=%0b ok=%0b",
                     want.pkt_type, want.pkt_length, want.has_data, want.data_byte,
                     want.byte_index, want.last, want.crc_ok);
            $display("  actual   type=%02h len=%02h has=%0b data=%02h idx=%0d last=%0b ok=%0b",
                     got.pkt_type, got.pkt_length, got.has_data, got.data_byte,
                     got.byte_index, got.last, got.crc_ok);
          end
        end
      end
    end
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Main sequence
  initial begin : stimulus
    bit         noise;
    int         counted;
    logic [7:0] sb;
    logic [7:0] ml;

    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    byte_if.valid     = 1'b0;
    byte_if.rx_byte   = 8'h00;
    deframe_reset();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed bytes under reset settings
    foreach (dir_tbl[i]) send_byte(dir_tbl[i].b, dir_tbl[i].typed, dir_tbl[i].want);

    // random phases: two settings per idling mode
    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin send_idle_pct = 7;  recv_idle_pct = 62; end
        1: begin send_idle_pct = 62; recv_idle_pct = 7;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (ph)
        0: begin sb = 8'h00; ml = 8'hFF; end
        1: begin sb = 8'hFF; ml = 8'h00; end
        3: begin sb = 8'h5A; ml = 8'd8;  end
        5: begin sb = START_BYTE_RST; ml = MAX_LENGTH_RST; end
        default: begin sb = $urandom; ml = $urandom_range(0, 255); end
      endcase
      drain();
      write_reg(REG_START_BYTE, sb);
      write_reg(REG_MAX_LENGTH, ml);
      counted = 0;
      while (counted < 300) begin
        build_frame(noise);
        foreach (frame_q[i]) send_byte(frame_q[i], 1'b0, NO_RES);
        if (!noise) counted += frame_q.size();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[packet_deframer_crc16.f]
hdl/pdc_pkg.sv
hdl/pdc_byte_if.sv
hdl/pdc_res_if.sv
hdl/pdc_cfg.sv
hdl/pdc_fsm.sv
hdl/pdc_obuf.sv
hdl/packet_deframer_crc16.sv
tb/sv/tb_packet_deframer_crc16.sv
